@@ rtl/dsep_pkg.sv @@
package dsep_pkg;

    localparam int DIST_BITS  = 32;
    localparam int IDX_W      = $clog2(DIST_BITS);
    localparam int SLOT_W     = IDX_W + 1;
    localparam int FVAL_W     = DIST_BITS - 2;
    localparam int BUF_W      = 7;
    localparam int FILL_W     = 3;
    localparam int ACC_W      = BUF_W + FVAL_W;
    localparam int TOT_W      = $clog2(ACC_W + 1);
    localparam int BYTE_W     = 8;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    localparam logic SEL_SLOT   = 1'b0;
    localparam logic SEL_FOOTER = 1'b1;

    typedef enum logic [1:0] {
        KIND_ENC   = 2'd0,
        KIND_BAD   = 2'd1,
        KIND_FLUSH = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [SLOT_W-1:0]  slot;
        logic [IDX_W-1:0]   fbits;
        logic [FVAL_W-1:0]  fval;
    } t_cmd;

endpackage

@@ rtl/dsep_front.sv @@
module dsep_front (
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_req_type,
    input  logic [31:0]          i_distance,
    output logic                 o_push,
    output dsep_pkg::t_cmd       o_cmd,
    input  logic                 i_full
);

    logic [dsep_pkg::DIST_BITS-1:0] d;
    logic [dsep_pkg::DIST_BITS-1:0] p;
    logic [dsep_pkg::IDX_W-1:0]     n;
    logic [dsep_pkg::IDX_W-1:0]     fbits;
    logic [dsep_pkg::FVAL_W-1:0]    fval;
    logic                           direct;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        d      = i_distance[dsep_pkg::DIST_BITS-1:0];
        p      = d - dsep_pkg::DIST_BITS'(1);
        direct = (p[dsep_pkg::DIST_BITS-1:2] == '0);
        n      = '0;
        for (int i = 1; i < dsep_pkg::DIST_BITS; i++) begin
            if (p[i]) begin
                n = dsep_pkg::IDX_W'(i);
            end
        end
        fbits = n - dsep_pkg::IDX_W'(1);
        for (int i = 0; i < dsep_pkg::FVAL_W; i++) begin
            fval[i] = p[i] && (dsep_pkg::IDX_W'(i) < fbits);
        end

        o_cmd.kind  = dsep_pkg::KIND_ENC;
        o_cmd.slot  = {n, p[n - dsep_pkg::IDX_W'(1)]};
        o_cmd.fbits = fbits;
        o_cmd.fval  = fval;
        if (i_req_type == dsep_pkg::REQ_FLUSH) begin
            o_cmd.kind  = dsep_pkg::KIND_FLUSH;
            o_cmd.fbits = '0;
            o_cmd.fval  = '0;
        end else if (d == '0) begin
            o_cmd.kind  = dsep_pkg::KIND_BAD;
            o_cmd.slot  = '0;
            o_cmd.fbits = '0;
            o_cmd.fval  = '0;
        end else if (direct) begin
            o_cmd.slot  = dsep_pkg::SLOT_W'(p[1:0]);
            o_cmd.fbits = '0;
            o_cmd.fval  = '0;
        end
    end

endmodule

@@ rtl/dsep_fifo.sv @@
module dsep_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dsep_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nonempty,
    output dsep_pkg::t_cmd  o_cmd
);

    dsep_pkg::t_cmd                    r_mem [dsep_pkg::FIFO_DEPTH];
    logic [dsep_pkg::FIFO_PTR_W-1:0]   r_wptr;
    logic [dsep_pkg::FIFO_PTR_W-1:0]   r_rptr;
    logic [dsep_pkg::FIFO_CNT_W-1:0]   r_count;
    logic [dsep_pkg::FIFO_CNT_W-1:0]   n_count;

    assign o_full     = (r_count == dsep_pkg::FIFO_CNT_W'(dsep_pkg::FIFO_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_cmd      = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + dsep_pkg::FIFO_CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - dsep_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == dsep_pkg::FIFO_PTR_W'(dsep_pkg::FIFO_DEPTH - 1))
                          ? '0 : r_wptr + dsep_pkg::FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == dsep_pkg::FIFO_PTR_W'(dsep_pkg::FIFO_DEPTH - 1))
                          ? '0 : r_rptr + dsep_pkg::FIFO_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

@@ rtl/dsep_back.sv @@
module dsep_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  dsep_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_stream_sel,
    output logic [7:0]      o_data_byte,
    output logic            o_bad_distance,
    output logic            o_last
);

    logic [dsep_pkg::BUF_W-1:0]  r_buf;
    logic [dsep_pkg::FILL_W-1:0] r_fill;
    logic                        r_busy;
    logic [dsep_pkg::ACC_W-1:0]  r_acc;
    logic [dsep_pkg::TOT_W-1:0]  r_tot;
    logic                        r_out_valid;
    logic                        r_sel;
    logic [7:0]                  r_byte;
    logic                        r_bad;
    logic                        r_last;

    logic [dsep_pkg::BUF_W-1:0]  n_buf;
    logic [dsep_pkg::FILL_W-1:0] n_fill;
    logic                        n_busy;
    logic [dsep_pkg::ACC_W-1:0]  n_acc;
    logic [dsep_pkg::TOT_W-1:0]  n_tot;
    logic                        n_out_valid;
    logic                        n_sel;
    logic [7:0]                  n_byte;
    logic                        n_bad;
    logic                        n_last;

    logic                        advance;
    logic [dsep_pkg::ACC_W-1:0]  acc;
    logic [dsep_pkg::TOT_W-1:0]  tot;
    logic [dsep_pkg::TOT_W-1:0]  tot_left;
    logic [dsep_pkg::ACC_W-1:0]  acc_left;

    assign advance        = !r_out_valid || i_ready;
    assign o_pop          = advance && !r_busy && i_cmd_valid;
    assign o_valid        = r_out_valid;
    assign o_stream_sel   = r_sel;
    assign o_data_byte    = r_byte;
    assign o_bad_distance = r_bad;
    assign o_last         = r_last;

    always_comb begin
        acc      = dsep_pkg::ACC_W'(r_buf) | (dsep_pkg::ACC_W'(i_cmd.fval) << r_fill);
        tot      = dsep_pkg::TOT_W'(r_fill) + dsep_pkg::TOT_W'(i_cmd.fbits);
        tot_left = r_tot - dsep_pkg::TOT_W'(dsep_pkg::BYTE_W);
        acc_left = r_acc >> dsep_pkg::BYTE_W;

        n_buf       = r_buf;
        n_fill      = r_fill;
        n_busy      = r_busy;
        n_acc       = r_acc;
        n_tot       = r_tot;
        n_out_valid = r_out_valid;
        n_sel       = r_sel;
        n_byte      = r_byte;
        n_bad       = r_bad;
        n_last      = r_last;

        if (advance) begin
            n_out_valid = 1'b0;
            if (r_busy) begin
                n_out_valid = 1'b1;
                n_sel       = dsep_pkg::SEL_FOOTER;
                n_byte      = r_acc[7:0];
                n_bad       = 1'b0;
                n_last      = (tot_left < dsep_pkg::TOT_W'(dsep_pkg::BYTE_W));
                n_acc       = acc_left;
                n_tot       = tot_left;
                if (n_last) begin
                    n_busy = 1'b0;
                    n_buf  = acc_left[dsep_pkg::BUF_W-1:0];
                    n_fill = tot_left[dsep_pkg::FILL_W-1:0];
                end
            end else if (i_cmd_valid) begin
                case (i_cmd.kind)
                    dsep_pkg::KIND_BAD: begin
                        n_out_valid = 1'b1;
                        n_sel       = dsep_pkg::SEL_SLOT;
                        n_byte      = '0;
                        n_bad       = 1'b1;
                        n_last      = 1'b1;
                    end
                    dsep_pkg::KIND_FLUSH: begin
                        if (r_fill != '0) begin
                            n_out_valid = 1'b1;
                            n_sel       = dsep_pkg::SEL_FOOTER;
                            n_byte      = {1'b0, r_buf};
                            n_bad       = 1'b0;
                            n_last      = 1'b1;
                            n_buf       = '0;
                            n_fill      = '0;
                        end
                    end
                    dsep_pkg::KIND_ENC: begin
                        n_out_valid = 1'b1;
                        n_sel       = dsep_pkg::SEL_SLOT;
                        n_byte      = 8'(i_cmd.slot);
                        n_bad       = 1'b0;
                        n_last      = (tot < dsep_pkg::TOT_W'(dsep_pkg::BYTE_W));
                        if (n_last) begin
                            n_buf  = acc[dsep_pkg::BUF_W-1:0];
                            n_fill = tot[dsep_pkg::FILL_W-1:0];
                        end else begin
                            n_busy = 1'b1;
                            n_acc  = acc;
                            n_tot  = tot;
                        end
                    end
                    default: begin
                        n_out_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf       <= '0;
            r_fill      <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_buf       <= n_buf;
            r_fill      <= n_fill;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_tot  <= n_tot;
        r_sel  <= n_sel;
        r_byte <= n_byte;
        r_bad  <= n_bad;
        r_last <= n_last;
    end

endmodule

@@ rtl/distance_slot_encoder_packer_top.sv @@
// Channel   Direction  Handshake          Beat contents
// input     in         i_valid / o_ready  i_req_type, i_distance
// output    out        o_valid / i_ready  o_stream_sel, o_data_byte, o_bad_distance, o_last
//
// An input beat is classified in the cycle it is accepted and queued in a two-entry queue.
// The back end gives one output beat per cycle while i_ready does not stall it: an item yields
// a slot byte, then any full footer bytes, through the single byte lane of the output register.
// A flush with an empty packer gives no beat.
// Reset is synchronous to the rising clock edge and clears the packer, the queue and the
// output valid flag.
// When the output stalls, the queue fills and then o_ready falls.
module distance_slot_encoder_packer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_distance,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_stream_sel,
    output logic [7:0]  o_data_byte,
    output logic        o_bad_distance,
    output logic        o_last
);

    dsep_pkg::t_cmd front_cmd;
    dsep_pkg::t_cmd queue_cmd;
    logic           push;
    logic           full;
    logic           pop;
    logic           nonempty;

    dsep_front u_front (
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_distance (i_distance),
        .o_push     (push),
        .o_cmd      (front_cmd),
        .i_full     (full)
    );

    dsep_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (front_cmd),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_cmd      (queue_cmd)
    );

    dsep_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (nonempty),
        .i_cmd          (queue_cmd),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_stream_sel   (o_stream_sel),
        .o_data_byte    (o_data_byte),
        .o_bad_distance (o_bad_distance),
        .o_last         (o_last)
    );

endmodule
